### design/dhfk_pkg.sv
// Package for the DH forward-kinematics block: fixed-point constants,
// angle offset table, CORDIC arctangent table and shared control types.
// No dependencies.
package dhfk_pkg;

    localparam int unsigned JOINTS_DEF        = 5;
    localparam int unsigned CORDIC_STAGES_DEF = 16;
    localparam int unsigned LINKS             = 5;

    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [33:0] CORDIC_X0   = 34'sh026DD3B6A;

    // Configuration register indexes
    localparam logic [2:0] REG_LINK_ONE   = 3'd0;
    localparam logic [2:0] REG_LINK_TWO   = 3'd1;
    localparam logic [2:0] REG_LINK_THREE = 3'd2;
    localparam logic [2:0] REG_LINK_FOUR  = 3'd3;
    localparam logic [2:0] REG_BASE_D     = 3'd4;
    localparam logic [2:0] REG_TOOL_D     = 3'd5;

    // DH angle offsets (0..4) and calibration angles (5..9), Q3.13
    function automatic logic signed [15:0] angle_rom(input logic [3:0] idx);
        unique case (idx)
            4'd0:    angle_rom = 16'sd25736;
            4'd1:    angle_rom = 16'sd12868;
            4'd2:    angle_rom = 16'sd0;
            4'd3:    angle_rom = -16'sd12868;
            4'd4:    angle_rom = 16'sd25736;
            4'd5:    angle_rom = 16'sd24306;
            4'd6:    angle_rom = 16'sd9294;
            4'd7:    angle_rom = -16'sd20875;
            4'd8:    angle_rom = 16'sd14655;
            4'd9:    angle_rom = 16'sd23949;
            default: angle_rom = 16'sd0;
        endcase
    endfunction

    function automatic logic signed [33:0] atan_rom(input logic [4:0] idx);
        unique case (idx)
            5'd0:  atan_rom = 34'sh03243F6A8;
            5'd1:  atan_rom = 34'sh01DAC6705;
            5'd2:  atan_rom = 34'sh00FADBAFC;
            5'd3:  atan_rom = 34'sh007F56EA6;
            5'd4:  atan_rom = 34'sh003FEAB76;
            5'd5:  atan_rom = 34'sh001FFD55B;
            5'd6:  atan_rom = 34'sh000FFFAAA;
            5'd7:  atan_rom = 34'sh0007FFF55;
            5'd8:  atan_rom = 34'sh0003FFFEA;
            5'd9:  atan_rom = 34'sh0001FFFFD;
            5'd10: atan_rom = 34'sh0000FFFFF;
            5'd11: atan_rom = 34'sh00007FFFF;
            5'd12: atan_rom = 34'sh00003FFFF;
            5'd13: atan_rom = 34'sh00001FFFF;
            5'd14: atan_rom = 34'sh00000FFFF;
            5'd15: atan_rom = 34'sh000007FFF;
            5'd16: atan_rom = 34'sh000003FFF;
            5'd17: atan_rom = 34'sh000001FFF;
            5'd18: atan_rom = 34'sh000000FFF;
            5'd19: atan_rom = 34'sh0000007FF;
            5'd20: atan_rom = 34'sh0000003FF;
            5'd21: atan_rom = 34'sh0000001FF;
            5'd22: atan_rom = 34'sh0000000FF;
            5'd23: atan_rom = 34'sh00000007F;
            default: atan_rom = 34'sh0;
        endcase
    endfunction

    // Saturate to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            sat16 = 16'sh7FFF;
        else if (v < -48'sd32768)
            sat16 = 16'sh8000;
        else
            sat16 = v[15:0];
    endfunction

    // Round half up from Q.28 products back to Q.14, saturated
    function automatic logic signed [15:0] round_q14(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = (v + 48'sd8192) >>> 14;
        round_q14 = sat16(t);
    endfunction

    // Datapath commands
    typedef struct packed {
        logic load;        // capture request, reset matrix to identity
        logic theta_calc;  // form reduced joint angle
        logic cordic_init;
        logic cordic_step;
        logic cordic_done; // round cos/sin
        logic link_pos;    // form link translation
        logic mac_clear;
        logic mac_step;    // one multiply-accumulate
        logic mac_store;   // round and store one entry
        logic commit;      // copy new matrix over old
    } dhfk_cmd_t;

    typedef struct packed {
        logic last_iter;
        logic last_entry;
        logic last_term;
    } dhfk_sts_t;

endpackage

### design/dhfk_if.sv
// Valid/ready channel interfaces for the DH forward-kinematics block.
// Depends on nothing.
interface dhfk_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [2:0]        joint_count;
    logic signed [15:0] angle_one;
    logic signed [15:0] angle_two;
    logic signed [15:0] angle_three;
    logic signed [15:0] angle_four;
    logic signed [15:0] angle_five;
    modport source (output valid, mode, joint_count, angle_one, angle_two,
                    angle_three, angle_four, angle_five, input ready);
    modport sink   (input valid, mode, joint_count, angle_one, angle_two,
                    angle_three, angle_four, angle_five, output ready);
endinterface

interface dhfk_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rot_xx, rot_xy, rot_xz;
    logic signed [15:0] rot_yx, rot_yy, rot_yz;
    logic signed [15:0] rot_zx, rot_zy, rot_zz;
    logic signed [15:0] pos_x, pos_y, pos_z;
    modport source (output valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
                    rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
                    rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z, output ready);
endinterface

### design/dh_forward_kinematics.sv
// Top level of the DH forward-kinematics block: configuration registers,
// sequencer and datapath. Uses dhfk_pkg, dhfk_if, dhfk_ctrl, dhfk_datapath.
//
//  channel   role    carries
//  req       sink    mode, joint_count, five joint angles
//  res       source  3x3 rotation and frame origin
//  cfg       write   six link lengths/offsets by index
//
// A request passes the accepting idle state, then per chained joint the angle,
// CORDIC init, CORDIC iteration, rounding and link states and the terms of
// the single multiply-accumulate unit, and last the result state.
// Reset loads the register defaults; no clearing pass.
// The result is held until taken; a new request is accepted afterwards.
module dh_forward_kinematics #(
    parameter int unsigned JOINTS        = dhfk_pkg::JOINTS_DEF,
    parameter int unsigned CORDIC_STAGES = dhfk_pkg::CORDIC_STAGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    dhfk_in_if.sink           req,
    dhfk_out_if.source        res,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import dhfk_pkg::*;

    logic signed [15:0] len_one_reg, len_two_reg, len_three_reg, len_four_reg;
    logic signed [15:0] base_d_reg, tool_d_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_one_reg   <= -16'sd541;
            len_two_reg   <= 16'sd2540;
            len_three_reg <= 16'sd2212;
            len_four_reg  <= -16'sd33;
            base_d_reg    <= 16'sd2376;
            tool_d_reg    <= -16'sd3031;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINK_ONE:   len_one_reg   <= cfg_data;
                REG_LINK_TWO:   len_two_reg   <= cfg_data;
                REG_LINK_THREE: len_three_reg <= cfg_data;
                REG_LINK_FOUR:  len_four_reg  <= cfg_data;
                REG_BASE_D:     base_d_reg    <= cfg_data;
                REG_TOOL_D:     tool_d_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    dhfk_cmd_t          cmd;
    dhfk_sts_t          sts;
    logic [2:0]         joint_idx;
    logic signed [15:0] rot [9];
    logic signed [15:0] pos [3];

    dhfk_ctrl #(.JOINTS(JOINTS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .joint_count (req.joint_count),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .joint_idx   (joint_idx),
        .cmd         (cmd),
        .sts         (sts)
    );

    dhfk_datapath #(.CORDIC_STAGES(CORDIC_STAGES)) u_dp (
        .clk            (clk),
        .cmd            (cmd),
        .sts            (sts),
        .joint_idx      (joint_idx),
        .mode           (req.mode),
        .angle_one      (req.angle_one),
        .angle_two      (req.angle_two),
        .angle_three    (req.angle_three),
        .angle_four     (req.angle_four),
        .angle_five     (req.angle_five),
        .link_len_one   (len_one_reg),
        .link_len_two   (len_two_reg),
        .link_len_three (len_three_reg),
        .link_len_four  (len_four_reg),
        .base_offset_d  (base_d_reg),
        .tool_offset_d  (tool_d_reg),
        .rot            (rot),
        .pos            (pos)
    );

    assign res.rot_xx = rot[0];
    assign res.rot_xy = rot[1];
    assign res.rot_xz = rot[2];
    assign res.rot_yx = rot[3];
    assign res.rot_yy = rot[4];
    assign res.rot_yz = rot[5];
    assign res.rot_zx = rot[6];
    assign res.rot_zy = rot[7];
    assign res.rot_zz = rot[8];
    assign res.pos_x  = pos[0];
    assign res.pos_y  = pos[1];
    assign res.pos_z  = pos[2];

endmodule

### design/dhfk_ctrl.sv
// Sequencer for the DH forward-kinematics block: walks joints, CORDIC
// iterations and the matrix multiply-accumulate terms. Uses dhfk_pkg.
module dhfk_ctrl #(
    parameter int unsigned JOINTS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          joint_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          joint_idx,
    output dhfk_pkg::dhfk_cmd_t cmd,
    input  dhfk_pkg::dhfk_sts_t sts
);
    import dhfk_pkg::*;

    localparam int unsigned MAXJ = (JOINTS < LINKS) ? JOINTS : LINKS;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_THETA  = 8'b0000_0010,
        ST_CINIT  = 8'b0000_0100,
        ST_CITER  = 8'b0000_1000,
        ST_CDONE  = 8'b0001_0000,
        ST_LINK   = 8'b0010_0000,
        ST_MAC    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] joint_reg, joint_next;
    logic [2:0] count_reg, count_next;
    logic [2:0] clamp;

    assign clamp = (joint_count > 3'(MAXJ)) ? 3'(MAXJ) : joint_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            joint_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            joint_reg <= joint_next;
            count_reg <= count_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign joint_idx = joint_reg;

    // Step through joints; each joint runs CORDIC then the matrix update
    always_comb
    begin
        state_next = state_reg;
        joint_next = joint_reg;
        count_next = count_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    joint_next = '0;
                    count_next = clamp;
                    state_next = (clamp == 3'd0) ? ST_OUT : ST_THETA;
                end
            end
            ST_THETA:
            begin
                cmd.theta_calc = 1'b1;
                state_next     = ST_CINIT;
            end
            ST_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = ST_CITER;
            end
            ST_CITER:
            begin
                cmd.cordic_step = 1'b1;
                if (sts.last_iter)
                    state_next = ST_CDONE;
            end
            ST_CDONE:
            begin
                cmd.cordic_done = 1'b1;
                state_next      = ST_LINK;
            end
            ST_LINK:
            begin
                cmd.link_pos  = 1'b1;
                cmd.mac_clear = 1'b1;
                state_next    = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (sts.last_term)
                begin
                    cmd.mac_store = 1'b1;
                end
                if (sts.last_term && sts.last_entry)
                begin
                    cmd.commit = 1'b1;
                    joint_next = joint_reg + 3'd1;
                    state_next = (joint_reg + 3'd1 == count_reg) ? ST_OUT : ST_THETA;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### design/dhfk_datapath.sv
// Datapath of the DH forward-kinematics block: angle reduction, iterative
// CORDIC, and a single multiply-accumulate for the chained link matrices.
// Uses dhfk_pkg.
module dhfk_datapath #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic                clk,
    input  dhfk_pkg::dhfk_cmd_t cmd,
    output dhfk_pkg::dhfk_sts_t sts,
    input  logic [2:0]          joint_idx,
    input  logic                mode,
    input  logic signed [15:0]  angle_one,
    input  logic signed [15:0]  angle_two,
    input  logic signed [15:0]  angle_three,
    input  logic signed [15:0]  angle_four,
    input  logic signed [15:0]  angle_five,
    input  logic signed [15:0]  link_len_one,
    input  logic signed [15:0]  link_len_two,
    input  logic signed [15:0]  link_len_three,
    input  logic signed [15:0]  link_len_four,
    input  logic signed [15:0]  base_offset_d,
    input  logic signed [15:0]  tool_offset_d,
    output logic signed [15:0]  rot [9],
    output logic signed [15:0]  pos [3]
);
    import dhfk_pkg::*;

    localparam int unsigned ITER_W = $clog2(CORDIC_STAGES);

    logic               mode_reg;
    logic signed [15:0] ang_reg [5];
    logic signed [17:0] theta_reg;
    logic               neg_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic signed [15:0] c_reg, s_reg;
    logic signed [15:0] pa_reg [3];
    logic signed [15:0] ra_reg [9];
    logic signed [15:0] r_reg [9];
    logic signed [15:0] p_reg [3];
    logic signed [15:0] nr_reg [9];
    logic signed [15:0] np_reg [3];
    logic [3:0]         entry_reg;   // 0..8 rotation, 9..11 position
    logic [1:0]         term_reg;    // 0..2 products, 3 for p*2^14
    logic signed [47:0] acc_reg;

    // Operands of current joint
    logic signed [15:0] ang_sel, a_sel, d_sel, cal_sel, off_sel;
    logic signed [17:0] th0, th1, th2;
    logic               neg_w;

    always_comb
    begin
        ang_sel = ang_reg[joint_idx];
        off_sel = angle_rom(4'(joint_idx));
        cal_sel = angle_rom(4'(joint_idx) + 4'd5);
        unique case (joint_idx)
            3'd0:    begin a_sel = link_len_one;   d_sel = base_offset_d; end
            3'd1:    begin a_sel = link_len_two;   d_sel = '0; end
            3'd2:    begin a_sel = link_len_three; d_sel = '0; end
            3'd3:    begin a_sel = link_len_four;  d_sel = '0; end
            3'd4:    begin a_sel = '0;             d_sel = tool_offset_d; end
            default: begin a_sel = '0;             d_sel = '0; end
        endcase
        th0 = 18'(ang_sel) + 18'(off_sel);
        if (mode_reg)
        begin
            if (joint_idx == 3'd0)
                th0 = 18'(cal_sel) - th0;
            else
                th0 = th0 - 18'(cal_sel);
        end
        // Wrap into one turn; at most two steps are needed for this range
        th1 = th0;
        if (th1 >= PI_Q13)
            th1 = th1 - TWO_PI_Q13;
        else if (th1 < -PI_Q13)
            th1 = th1 + TWO_PI_Q13;
        if (th1 >= PI_Q13)
            th1 = th1 - TWO_PI_Q13;
        else if (th1 < -PI_Q13)
            th1 = th1 + TWO_PI_Q13;
        // Fold into the right half plane
        neg_w = 1'b0;
        th2   = th1;
        if (th1 > HALF_PI_Q13)
        begin
            th2   = th1 - PI_Q13;
            neg_w = 1'b1;
        end
        else if (th1 < -HALF_PI_Q13)
        begin
            th2   = th1 + PI_Q13;
            neg_w = 1'b1;
        end
    end

    // CORDIC step with floor shifts
    logic signed [33:0] dx, dy, xf, yf;
    logic signed [47:0] cr, sr;
    always_comb
    begin
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
        cr = (48'(xf) + 48'sd32768) >>> 16;
        sr = (48'(yf) + 48'sd32768) >>> 16;
    end

    // Multiply-accumulate operands
    logic [1:0]         row, col;
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] prod;
    logic               is_pos;
    always_comb
    begin
        is_pos = (entry_reg >= 4'd9);
        // Map the entry counter to row and column of the product
        unique case (entry_reg)
            4'd0:    begin row = 2'd0; col = 2'd0; end
            4'd1:    begin row = 2'd0; col = 2'd1; end
            4'd2:    begin row = 2'd0; col = 2'd2; end
            4'd3:    begin row = 2'd1; col = 2'd0; end
            4'd4:    begin row = 2'd1; col = 2'd1; end
            4'd5:    begin row = 2'd1; col = 2'd2; end
            4'd6:    begin row = 2'd2; col = 2'd0; end
            4'd7:    begin row = 2'd2; col = 2'd1; end
            4'd8:    begin row = 2'd2; col = 2'd2; end
            4'd9:    begin row = 2'd0; col = 2'd0; end
            4'd10:   begin row = 2'd1; col = 2'd0; end
            4'd11:   begin row = 2'd2; col = 2'd0; end
            default: begin row = 2'd0; col = 2'd0; end
        endcase
        if (term_reg == 2'd3)
        begin
            mul_a = p_reg[row];
            mul_b = ONE_Q14;
        end
        else
        begin
            mul_a = r_reg[4'(row) * 4'd3 + 4'(term_reg)];
            mul_b = is_pos ? pa_reg[term_reg]
                           : ra_reg[4'(term_reg) * 4'd3 + 4'(col)];
        end
        prod = mul_a * mul_b;
    end

    logic signed [47:0] acc_sum;
    assign acc_sum = acc_reg + 48'(prod);

    assign sts.last_iter  = (iter_reg == ITER_W'(CORDIC_STAGES - 1));
    assign sts.last_entry = (entry_reg == 4'd11);
    assign sts.last_term  = is_pos ? (term_reg == 2'd3) : (term_reg == 2'd2);

    logic signed [47:0] pac, pas;
    assign pac = 48'(a_sel) * 48'(c_reg);
    assign pas = 48'(a_sel) * 48'(s_reg);

    // Hold request, advance CORDIC and matrix accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            ang_reg[0] <= angle_one;
            ang_reg[1] <= angle_two;
            ang_reg[2] <= angle_three;
            ang_reg[3] <= angle_four;
            ang_reg[4] <= angle_five;
            for (int i = 0; i < 9; i++)
                r_reg[i] <= (i % 4 == 0) ? ONE_Q14 : 16'sd0;
            for (int i = 0; i < 3; i++)
                p_reg[i] <= '0;
        end
        if (cmd.theta_calc)
        begin
            theta_reg <= th2;
            neg_reg   <= neg_w;
        end
        if (cmd.cordic_init)
        begin
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= 34'(theta_reg) <<< 17;
            iter_reg <= '0;
        end
        if (cmd.cordic_step)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_rom(5'(iter_reg));
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_rom(5'(iter_reg));
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.cordic_done)
        begin
            c_reg <= sat16(cr);
            s_reg <= sat16(sr);
        end
        if (cmd.link_pos)
        begin
            pa_reg[0] <= round_q14(pac);
            pa_reg[1] <= round_q14(pas);
            pa_reg[2] <= d_sel;
            // Link rotation: twist fixed per joint
            unique case (joint_idx)
                3'd0, 3'd3:
                begin
                    ra_reg[0] <= c_reg; ra_reg[1] <= '0;     ra_reg[2] <= s_reg;
                    ra_reg[3] <= s_reg; ra_reg[4] <= '0;     ra_reg[5] <= -c_reg;
                    ra_reg[6] <= '0;    ra_reg[7] <= ONE_Q14; ra_reg[8] <= '0;
                end
                3'd4:
                begin
                    ra_reg[0] <= c_reg; ra_reg[1] <= s_reg;  ra_reg[2] <= '0;
                    ra_reg[3] <= s_reg; ra_reg[4] <= -c_reg; ra_reg[5] <= '0;
                    ra_reg[6] <= '0;    ra_reg[7] <= '0;     ra_reg[8] <= -ONE_Q14;
                end
                default:
                begin
                    ra_reg[0] <= c_reg; ra_reg[1] <= -s_reg; ra_reg[2] <= '0;
                    ra_reg[3] <= s_reg; ra_reg[4] <= c_reg;  ra_reg[5] <= '0;
                    ra_reg[6] <= '0;    ra_reg[7] <= '0;     ra_reg[8] <= ONE_Q14;
                end
            endcase
        end
        if (cmd.mac_clear)
        begin
            entry_reg <= '0;
            term_reg  <= '0;
            acc_reg   <= '0;
        end
        if (cmd.mac_step)
        begin
            if (cmd.mac_store)
            begin
                if (is_pos)
                    np_reg[row] <= round_q14(acc_sum);
                else
                    nr_reg[entry_reg] <= round_q14(acc_sum);
                acc_reg   <= '0;
                term_reg  <= '0;
                entry_reg <= entry_reg + 4'd1;
            end
            else
            begin
                acc_reg  <= acc_sum;
                term_reg <= term_reg + 2'd1;
            end
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < 9; i++)
                r_reg[i] <= nr_reg[i];
            p_reg[0] <= np_reg[0];
            p_reg[1] <= np_reg[1];
            p_reg[2] <= round_q14(acc_sum);
        end
    end

    assign rot = r_reg;
    assign pos = p_reg;

endmodule

### design/dhfk_checker.sv
// Port-level checks on the DH forward-kinematics block, bound to its top.
// Depends on dh_forward_kinematics and dhfk_if.
module dhfk_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input logic [15:0] res_pos_x
);
    // No request taken while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req_ready) else $error("request taken with result pending");
    // After a taken request, result valid and request ready do not both hold
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !res_valid || !req_ready)
        else $error("result too early");
    // Result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid && $stable(res_pos_x))
        else $error("result dropped");
    // After delivery the block is ready again
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> req_ready) else $error("not ready after result");
endmodule

bind dh_forward_kinematics dhfk_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_pos_x (res.pos_x)
);

### verif/tb_dh_forward_kinematics.sv
// Self-checking testbench for dh_forward_kinematics: drives joint-angle
// requests, predicts pose results in fixed point and compares them in order.
// Depends on dhfk_pkg, dhfk_if and the block's RTL.
`timescale 1ns / 100ps

module tb_dh_forward_kinematics;
    import dhfk_pkg::*;

    typedef struct packed {
        logic               mode;
        logic [2:0]         joint_count;
        logic signed [15:0] ang1, ang2, ang3, ang4, ang5;
    } pose_req_t;

    typedef struct packed {
        logic signed [15:0] rxx, rxy, rxz, ryx, ryy, ryz, rzx, rzy, rzz;
        logic signed [15:0] px, py, pz;
    } pose_res_t;

    localparam int JOINT_CYCLES = 60;
    localparam int SLOW_WAIT    = 2 + 5 * JOINT_CYCLES + 20;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    dhfk_in_if  req_if ();
    dhfk_out_if res_if ();

    dh_forward_kinematics u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if.sink),
        .res       (res_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the configuration registers
    logic signed [15:0] link_a [0:3];
    logic signed [15:0] base_d, tool_d;

    pose_req_t pending_reqs[$];
    pose_res_t expected_poses[$];
    int  errors = 0;
    int  accepted = 0;
    int  checked = 0;
    bit  drive_gaps, sink_gaps, hold_sink;
    int  src_idle, sink_idle;

    localparam int OFFS [0:9] = '{25736, 12868, 0, -12868, 25736,
                                  24306, 9294, -20875, 14655, 23949};
    localparam longint ATANS [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint to_q14(longint v);
        return clamp16((v + 8192) >>> 14);
    endfunction

    // Rotation-mode CORDIC on a reduced joint angle
    task automatic joint_trig(input longint theta, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = 64'h26DD3B6A;
        y = 0;
        flip = 0;
        while (theta >= 25736)
            theta -= 51472;
        while (theta < -25736)
            theta += 51472;
        if (theta > 12868)
        begin
            theta -= 25736;
            flip = 1;
        end
        else if (theta < -12868)
        begin
            theta += 25736;
            flip = 1;
        end
        z = theta * 131072;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATANS[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATANS[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = clamp16((x + 32768) >>> 16);
        s = clamp16((y + 32768) >>> 16);
    endtask

    // Chain DH links up to the requested frame
    task automatic predict_pose(input pose_req_t rq, output pose_res_t rs);
        longint rm [3][3];
        longint nr [3][3];
        longint ra [3][3];
        longint p [3];
        longint np [3];
        longint pa [3];
        longint ang [5];
        longint a_len [5];
        longint d_len [5];
        int ca [5];
        int sa [5];
        longint theta, c, s, sum, acc;
        int cnt;
        ca = '{0, 1, 1, 0, -1};
        sa = '{1, 0, 0, 1, 0};
        ang = '{rq.ang1, rq.ang2, rq.ang3, rq.ang4, rq.ang5};
        a_len = '{link_a[0], link_a[1], link_a[2], link_a[3], 0};
        d_len = '{base_d, 0, 0, 0, tool_d};
        for (int r = 0; r < 3; r++)
        begin
            p[r] = 0;
            for (int k = 0; k < 3; k++)
                rm[r][k] = (r == k) ? 16384 : 0;
        end
        cnt = (rq.joint_count > 5) ? 5 : rq.joint_count;
        for (int i = 0; i < cnt; i++)
        begin
            theta = ang[i] + OFFS[i];
            if (rq.mode)
                theta = (i == 0) ? OFFS[5] - theta : theta - OFFS[5 + i];
            joint_trig(theta, c, s);
            ra[0][0] = c; ra[0][1] = -s * ca[i]; ra[0][2] = s * sa[i];
            ra[1][0] = s; ra[1][1] = c * ca[i];  ra[1][2] = -c * sa[i];
            ra[2][0] = 0; ra[2][1] = sa[i] * 16384; ra[2][2] = ca[i] * 16384;
            pa[0] = to_q14(a_len[i] * c);
            pa[1] = to_q14(a_len[i] * s);
            pa[2] = d_len[i];
            for (int r = 0; r < 3; r++)
            begin
                acc = p[r] * 16384;
                for (int k = 0; k < 3; k++)
                begin
                    sum = 0;
                    for (int m = 0; m < 3; m++)
                        sum += rm[r][m] * ra[m][k];
                    nr[r][k] = to_q14(sum);
                    acc += rm[r][k] * pa[k];
                end
                np[r] = to_q14(acc);
            end
            rm = nr;
            p = np;
        end
        rs = '{rm[0][0], rm[0][1], rm[0][2], rm[1][0], rm[1][1], rm[1][2],
               rm[2][0], rm[2][1], rm[2][2], p[0], p[1], p[2]};
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s on result %0d: got %0d want %0d", what, checked, got, want);
    endtask

    // Driver: present queued requests, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        pose_res_t pr;
        if (!rst_n)
        begin
            req_if.valid       <= 1'b0;
            req_if.mode        <= 1'b0;
            req_if.joint_count <= '0;
            req_if.angle_one   <= '0;
            req_if.angle_two   <= '0;
            req_if.angle_three <= '0;
            req_if.angle_four  <= '0;
            req_if.angle_five  <= '0;
            src_idle           <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                predict_pose(pending_reqs.pop_front(), pr);
                expected_poses.push_back(pr);
                accepted++;
            end
            if (req_if.valid && !req_if.ready)
                ;
            else if (src_idle > 0)
            begin
                src_idle <= src_idle - 1;
                req_if.valid <= 1'b0;
            end
            else if (drive_gaps && $urandom_range(0, 7) == 0)
            begin
                src_idle <= $urandom_range(1, 12) - 1;
                req_if.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_if.valid       <= 1'b1;
                req_if.mode        <= pending_reqs[0].mode;
                req_if.joint_count <= pending_reqs[0].joint_count;
                req_if.angle_one   <= pending_reqs[0].ang1;
                req_if.angle_two   <= pending_reqs[0].ang2;
                req_if.angle_three <= pending_reqs[0].ang3;
                req_if.angle_four  <= pending_reqs[0].ang4;
                req_if.angle_five  <= pending_reqs[0].ang5;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // Monitor: accept results, compare against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        pose_res_t want, got;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            sink_idle    <= 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got = '{res_if.rot_xx, res_if.rot_xy, res_if.rot_xz, res_if.rot_yx,
                        res_if.rot_yy, res_if.rot_yz, res_if.rot_zx, res_if.rot_zy,
                        res_if.rot_zz, res_if.pos_x, res_if.pos_y, res_if.pos_z};
                if (expected_poses.size() == 0)
                    report_mismatch("unexpected result, pos_x", got.px, 0);
                else
                begin
                    want = expected_poses.pop_front();
                    if (got.rxx != want.rxx) report_mismatch("rot_xx", got.rxx, want.rxx);
                    if (got.rxy != want.rxy) report_mismatch("rot_xy", got.rxy, want.rxy);
                    if (got.rxz != want.rxz) report_mismatch("rot_xz", got.rxz, want.rxz);
                    if (got.ryx != want.ryx) report_mismatch("rot_yx", got.ryx, want.ryx);
                    if (got.ryy != want.ryy) report_mismatch("rot_yy", got.ryy, want.ryy);
                    if (got.ryz != want.ryz) report_mismatch("rot_yz", got.ryz, want.ryz);
                    if (got.rzx != want.rzx) report_mismatch("rot_zx", got.rzx, want.rzx);
                    if (got.rzy != want.rzy) report_mismatch("rot_zy", got.rzy, want.rzy);
                    if (got.rzz != want.rzz) report_mismatch("rot_zz", got.rzz, want.rzz);
                    if (got.px != want.px) report_mismatch("pos_x", got.px, want.px);
                    if (got.py != want.py) report_mismatch("pos_y", got.py, want.py);
                    if (got.pz != want.pz) report_mismatch("pos_z", got.pz, want.pz);
                end
                checked++;
            end
            if (hold_sink)
                res_if.ready <= 1'b0;
            else if (sink_idle > 0)
            begin
                sink_idle <= sink_idle - 1;
                res_if.ready <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 7) == 0)
            begin
                sink_idle <= $urandom_range(1, 12) - 1;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Long receiver hold-off, counted in its own process
    initial
    begin
        hold_sink = 1'b0;
        wait (accepted >= 40);
        hold_sink = 1'b1;
        repeat (3000) @(posedge clk);
        hold_sink = 1'b0;
    end

    task automatic queue_req(input int m, input int jc, input int a1,
                             input int a2, input int a3,
                             input int a4, input int a5);
        pending_reqs.push_back('{1'(m), 3'(jc), 16'(a1), 16'(a2), 16'(a3),
                                 16'(a4), 16'(a5)});
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_req($urandom_range(0, 1), $urandom_range(0, 7), $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            else
                queue_req($urandom_range(0, 1), $urandom_range(1, 5),
                          $urandom_range(0, 51472) - 25736, $urandom_range(0, 51472) - 25736,
                          $urandom_range(0, 51472) - 25736, $urandom_range(0, 51472) - 25736,
                          $urandom_range(0, 51472) - 25736);
        end
    endtask

    // Wait for the block to drain before touching registers
    task automatic drain;
        wait (pending_reqs.size() == 0 && !req_if.valid && expected_poses.size() == 0);
        repeat (SLOW_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LINK_ONE:   link_a[0] = val;
            REG_LINK_TWO:   link_a[1] = val;
            REG_LINK_THREE: link_a[2] = val;
            REG_LINK_FOUR:  link_a[3] = val;
            REG_BASE_D:     base_d = val;
            REG_TOOL_D:     tool_d = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input int v0, input int v1);
        write_reg(REG_LINK_ONE, 16'(v0));
        write_reg(REG_LINK_TWO, 16'(v1));
        write_reg(REG_LINK_THREE, 16'(v0));
        write_reg(REG_LINK_FOUR, 16'(v1));
        write_reg(REG_BASE_D, 16'(v1));
        write_reg(REG_TOOL_D, 16'(v0));
    endtask

    // Stimulus
    initial
    begin
        drive_gaps = 1'b1; sink_gaps = 1'b1;
        cfg_we = 1'b0; cfg_index = REG_LINK_ONE; cfg_data = '0;
        link_a = '{-541, 2540, 2212, -33};
        base_d = 2376; tool_d = -3031;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: counts from zero to above five, both modes, angle extremes
        for (int jc = 0; jc < 8; jc++)
            queue_req(jc % 2, jc, 0, 0, 0, 0, 0);
        queue_req(0, 5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_req(1, 5, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_req(1, 5, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        queue_req(0, 5, 12868, -12868, 25736, -25736, 0);
        queue_req(1, 3, -1, 1, -1, 1, -1);
        queue_req(0, 7, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        queue_random(200);
        drain();

        // Register extremes: saturating positions
        write_all(16'h7FFF, 16'h8000);
        queue_req(0, 5, 0, 0, 0, 0, 0);
        queue_req(1, 5, 16'h7FFF, 0, 16'h8000, 0, 16'h7FFF);
        queue_random(400);
        drain();
        write_all(16'h8000, 16'h7FFF);
        queue_random(400);
        drain();
        write_all($urandom, $urandom);
        queue_random(300);

        // Sender pauses until every result is home
        drain();
        queue_random(250);
        drain();
        write_all(0, 0);
        queue_random(100);
        drain();

        // Last stretch with no idling on either side
        drive_gaps = 1'b0; sink_gaps = 1'b0;
        queue_random(100);
        drain();

        $display("covered %0d requests and %0d results over five register settings",
                 accepted, checked);
        if (errors == 0)
            $display("PASS dh_forward_kinematics");
        else
            $display("FAIL dh_forward_kinematics");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(64'd200_000_000);
        $display("FAIL dh_forward_kinematics");
        $finish;
    end

endmodule
